>>> hw/rtl/pgq_pkg.sv
// shared constants and types for the pose grid quantizer
// used by every module of the block but the divider, no dependencies of its own
package pgq_pkg;

  localparam int DIV_W   = 31;  // quotient bits, one divider step per stage
  localparam int CELL_W  = 24;
  localparam int BINS_W  = 11;
  localparam int PHASE_W = 16;
  localparam int BIN_W   = 10;
  localparam int POS_W   = 32;
  localparam int CFG_W   = 24;

  localparam logic [BINS_W-1:0] MAX_HEADING_BINS = 11'd1024;
  localparam logic [BINS_W-1:0] MIN_HEADING_BINS = 11'd2;
  localparam logic [CELL_W-1:0] CELL_SIZE_RESET  = 24'd2560;
  localparam logic [BINS_W-1:0] HEADING_BINS_RESET = 11'd16;

  // per stage load enables for stages 0 .. DIV_W of a lane
  typedef logic [DIV_W:0] lane_en_t;

  typedef enum logic [0:0] {
    REG_CELL_SIZE    = 1'b0,
    REG_HEADING_BINS = 1'b1
  } cfg_idx_t;

  typedef enum logic [0:0] {
    CMD_TO_GRID       = 1'b0,
    CMD_TO_CONTINUOUS = 1'b1
  } cmd_t;

endpackage

>>> hw/rtl/pgq_divider.sv
// pipelined restoring divider, one quotient bit per stage
// stage enables come from the block's pipeline control; depends on nothing else
module pgq_divider #(
  parameter int NUM_W = 31,
  parameter int DEN_W = 24
) (
  input  logic             clk,
  input  logic [NUM_W:0]   en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  logic [DEN_W-1:0] pr [1:NUM_W];
  logic [NUM_W-1:0] nq [1:NUM_W];
  logic [DEN_W-1:0] dv [1:NUM_W];

  for (genvar j = 1; j <= NUM_W; j++) begin : g_stage
    logic [DEN_W-1:0] pr_prev;
    logic [NUM_W-1:0] nq_prev;
    logic [DEN_W-1:0] dv_prev;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (j == 1) begin : g_first
      assign pr_prev = '0;
      assign nq_prev = num;
      assign dv_prev = den;
    end else begin : g_next
      assign pr_prev = pr[j-1];
      assign nq_prev = nq[j-1];
      assign dv_prev = dv[j-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign trial = {pr_prev, nq_prev[NUM_W-1]};
    assign ge    = trial >= {1'b0, dv_prev};
    assign diff  = trial - {1'b0, dv_prev};

    always_ff @(posedge clk) begin
      if (en[j]) begin
        pr[j] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nq[j] <= {nq_prev[NUM_W-2:0], ge};
        dv[j] <= dv_prev;
      end
    end
  end

  assign quo = nq[NUM_W];

endmodule

>>> hw/rtl/pgq_axis_lane.sv
// one position axis: floor division by the cell size and cell centre with clamp
// uses pgq_pkg and pgq_divider
module pgq_axis_lane
  import pgq_pkg::*;
(
  input  logic                    clk,
  input  lane_en_t                en,
  input  logic signed [POS_W-1:0] pos,
  input  logic signed [POS_W-1:0] grid,
  input  logic [CELL_W-1:0]       cell_sz,
  output logic [POS_W-1:0]        cell_idx,
  output logic [POS_W-1:0]        centre,
  output logic                    sat
);

  localparam int PROD_W = POS_W + CELL_W + 1;

  logic [DIV_W-1:0]         num0;
  logic                     neg0;
  logic [CELL_W-1:0]        den0;
  logic signed [PROD_W-1:0] prod0;
  logic [CELL_W-2:0]        half0;

  logic [POS_W-1:0] val_s [1:DIV_W];
  logic             sat_s [1:DIV_W];
  logic             neg_s [1:DIV_W];

  logic [PROD_W:0]  sum;
  logic             ovf;
  logic [POS_W-1:0] clamped;
  logic [DIV_W-1:0] quo;

  // negative dividend: floor(a/b) = ~(~a / b)
  always_ff @(posedge clk) begin
    if (en[0]) begin
      num0  <= pos[POS_W-1] ? ~pos[DIV_W-1:0] : pos[DIV_W-1:0];
      neg0  <= pos[POS_W-1];
      den0  <= cell_sz;
      prod0 <= grid * $signed({1'b0, cell_sz});
      half0 <= cell_sz[CELL_W-1:1];
    end
  end

  pgq_divider #(
    .NUM_W(DIV_W),
    .DEN_W(CELL_W)
  ) u_div (
    .clk(clk),
    .en (en),
    .num(num0),
    .den(den0),
    .quo(quo)
  );

  always_comb begin
    sum = {prod0[PROD_W-1], prod0} + {{(PROD_W-CELL_W+2){1'b0}}, half0};
    // fits 32 bits only when the upper bits are all copies of the sign
    ovf = !((&sum[PROD_W:POS_W-1]) || !(|sum[PROD_W:POS_W-1]));
    if (!ovf) begin
      clamped = sum[POS_W-1:0];
    end else if (sum[PROD_W]) begin
      clamped = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      clamped = {1'b0, {(POS_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      val_s[1] <= clamped;
      sat_s[1] <= ovf;
      neg_s[1] <= neg0;
    end
    for (int k = 2; k <= DIV_W; k++) begin
      if (en[k]) begin
        val_s[k] <= val_s[k-1];
        sat_s[k] <= sat_s[k-1];
        neg_s[k] <= neg_s[k-1];
      end
    end
  end

  assign cell_idx = neg_s[DIV_W] ? ~{1'b0, quo} : {1'b0, quo};
  assign centre   = val_s[DIV_W];
  assign sat      = sat_s[DIV_W];

endmodule

>>> hw/rtl/pgq_heading_lane.sv
// heading lane: phase to bin by one multiply, bin to phase by pipelined division
// uses pgq_pkg and pgq_divider
module pgq_heading_lane
  import pgq_pkg::*;
(
  input  logic               clk,
  input  lane_en_t           en,
  input  logic [PHASE_W-1:0] phase,
  input  logic [BIN_W-1:0]   index,
  input  logic [BINS_W-1:0]  bin_count,
  output logic [BIN_W-1:0]   bin,
  output logic [PHASE_W-1:0] bin_phase
);

  localparam int PROD_W = BINS_W + PHASE_W;

  logic [DIV_W-1:0]  num0;
  logic [BINS_W-1:0] den0;
  logic [PROD_W-1:0] prod0;

  logic [BIN_W-1:0]  bin_s [1:DIV_W];

  logic [PROD_W-1:0] rnd;
  logic [BINS_W-1:0] t;
  logic [DIV_W-1:0]  quo;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      num0  <= {{(DIV_W-BIN_W-PHASE_W){1'b0}}, index, {PHASE_W{1'b0}}};
      den0  <= bin_count;
      prod0 <= bin_count * phase;
    end
  end

  pgq_divider #(
    .NUM_W(DIV_W),
    .DEN_W(BINS_W)
  ) u_div (
    .clk(clk),
    .en (en),
    .num(num0),
    .den(den0),
    .quo(quo)
  );

  // bin = round(n*phase / turn), and a full turn folds back to bin zero
  always_comb begin
    rnd = prod0 + {{(PROD_W-PHASE_W){1'b0}}, 1'b1, {(PHASE_W-1){1'b0}}};
    t   = rnd[PROD_W-1:PHASE_W];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      bin_s[1] <= (t == den0) ? '0 : t[BIN_W-1:0];
    end
    for (int k = 2; k <= DIV_W; k++) begin
      if (en[k]) begin
        bin_s[k] <= bin_s[k-1];
      end
    end
  end

  assign bin       = bin_s[DIV_W];
  assign bin_phase = quo[PHASE_W-1:0];

endmodule

>>> hw/rtl/pose_grid_quantizer.sv
// Pose grid quantizer.
// Items enter on the item channel (item_valid / item_stall) and leave on the
// result channel (result_valid / result_stall); a transfer happens at a rising
// edge with valid high and stall low. command 0 maps a continuous pose to grid
// cells and a heading bin, command 1 maps cells and a bin back to the cell
// centre and bin heading, with the position clamped to 32 bits and flagged.
// Fields not used by the command read as zero.
// cell_size and heading_bins are written on the cfg channel (always ready); the
// user must do so only while no item is in flight, as the block does not check.
// Reset gives 2560 mm cells and 16 bins. Throughput: one item per cycle while
// item_stall is low, set by the 31 stage restoring dividers (one quotient bit
// per stage) that run in the x, y and heading lanes side by side.
// When the receiver stalls, the result holds and the pipeline keeps taking
// items until every stage is full; only then is item_stall raised.
// Reset clears the pipeline and restores the registers.
// uses pgq_pkg, pgq_axis_lane, pgq_heading_lane
module pose_grid_quantizer
  import pgq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [0:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic                    command,
  input  logic signed [POS_W-1:0] pos_x_mm,
  input  logic signed [POS_W-1:0] pos_y_mm,
  input  logic [PHASE_W-1:0]      heading_phase,
  input  logic signed [POS_W-1:0] grid_x,
  input  logic signed [POS_W-1:0] grid_y,
  input  logic [BIN_W-1:0]        heading_index,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic signed [POS_W-1:0] out_grid_x,
  output logic signed [POS_W-1:0] out_grid_y,
  output logic [BIN_W-1:0]        out_heading_index,
  output logic signed [POS_W-1:0] out_x_mm,
  output logic signed [POS_W-1:0] out_y_mm,
  output logic [PHASE_W-1:0]      out_heading_phase,
  output logic                    saturated
);

  localparam int STG_W = DIV_W + 2;

  logic [CELL_W-1:0] cell_size;
  logic [BINS_W-1:0] heading_bins;
  logic [CELL_W-1:0] cell_eff;
  logic [BINS_W-1:0] bins_eff;

  logic [STG_W-1:0] vld;
  logic [STG_W-1:0] en;
  cmd_t             cmd_s [0:DIV_W];

  logic [POS_W-1:0]   x_idx, y_idx, x_mm, y_mm;
  logic               x_sat, y_sat;
  logic [BIN_W-1:0]   bin;
  logic [PHASE_W-1:0] bin_phase;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size    <= CELL_SIZE_RESET;
      heading_bins <= HEADING_BINS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        REG_CELL_SIZE:    cell_size    <= cfg_data[CELL_W-1:0];
        REG_HEADING_BINS: heading_bins <= cfg_data[BINS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cell_eff = (cell_size == '0) ? {{(CELL_W-1){1'b0}}, 1'b1} : cell_size;
    if (heading_bins < MIN_HEADING_BINS) begin
      bins_eff = MIN_HEADING_BINS;
    end else if (heading_bins > MAX_HEADING_BINS) begin
      bins_eff = MAX_HEADING_BINS;
    end else begin
      bins_eff = heading_bins;
    end
  end

  // a stage loads unless the receiver stalls while it and every stage after it are full
  always_comb begin
    for (int k = 0; k < STG_W; k++) begin
      en[k] = !(result_stall &&
                (&(vld | ((STG_W'(1) << k) - STG_W'(1)))));
    end
  end

  assign item_stall   = !en[0];
  assign result_valid = vld[STG_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= item_valid;
      end
      for (int k = 1; k < STG_W; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cmd_s[0] <= cmd_t'(command);
    end
    for (int k = 1; k <= DIV_W; k++) begin
      if (en[k]) begin
        cmd_s[k] <= cmd_s[k-1];
      end
    end
  end

  pgq_axis_lane u_lane_x (
    .clk     (clk),
    .en      (en[DIV_W:0]),
    .pos     (pos_x_mm),
    .grid    (grid_x),
    .cell_sz (cell_eff),
    .cell_idx(x_idx),
    .centre  (x_mm),
    .sat     (x_sat)
  );

  pgq_axis_lane u_lane_y (
    .clk     (clk),
    .en      (en[DIV_W:0]),
    .pos     (pos_y_mm),
    .grid    (grid_y),
    .cell_sz (cell_eff),
    .cell_idx(y_idx),
    .centre  (y_mm),
    .sat     (y_sat)
  );

  pgq_heading_lane u_lane_h (
    .clk      (clk),
    .en       (en[DIV_W:0]),
    .phase    (heading_phase),
    .index    (heading_index),
    .bin_count(bins_eff),
    .bin      (bin),
    .bin_phase(bin_phase)
  );

  // merge the lanes into the result register, unused fields zero
  always_ff @(posedge clk) begin
    if (en[STG_W-1]) begin
      case (cmd_s[DIV_W])
        CMD_TO_GRID: begin
          out_grid_x        <= x_idx;
          out_grid_y        <= y_idx;
          out_heading_index <= bin;
          out_x_mm          <= '0;
          out_y_mm          <= '0;
          out_heading_phase <= '0;
          saturated         <= 1'b0;
        end
        default: begin
          out_grid_x        <= '0;
          out_grid_y        <= '0;
          out_heading_index <= '0;
          out_x_mm          <= x_mm;
          out_y_mm          <= y_mm;
          out_heading_phase <= bin_phase;
          saturated         <= x_sat || y_sat;
        end
      endcase
    end
  end

endmodule

>>> tb/pose_grid_quantizer_checker.sv
// scoreboard for the pose grid quantizer: watches the register, item and result channels,
// predicts every result from its own copy of the registers and compares field by field
// depends on pgq_pkg for widths, reset values and codes
module pose_grid_quantizer_checker
  import pgq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [0:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    item_valid,
  input  logic                    item_stall,
  input  logic                    command,
  input  logic signed [POS_W-1:0] pos_x_mm,
  input  logic signed [POS_W-1:0] pos_y_mm,
  input  logic [PHASE_W-1:0]      heading_phase,
  input  logic signed [POS_W-1:0] grid_x,
  input  logic signed [POS_W-1:0] grid_y,
  input  logic [BIN_W-1:0]        heading_index,
  input  logic                    result_valid,
  input  logic                    result_stall,
  input  logic signed [POS_W-1:0] out_grid_x,
  input  logic signed [POS_W-1:0] out_grid_y,
  input  logic [BIN_W-1:0]        out_heading_index,
  input  logic signed [POS_W-1:0] out_x_mm,
  input  logic signed [POS_W-1:0] out_y_mm,
  input  logic [PHASE_W-1:0]      out_heading_phase,
  input  logic                    saturated,
  output int                      mismatches,
  output int                      awaiting,
  output int                      checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint POS_MAX = (64'sd1 <<< 31) - 1;
  localparam longint POS_MIN = -(64'sd1 <<< 31);

  typedef struct {
    logic signed [POS_W-1:0] gx;
    logic signed [POS_W-1:0] gy;
    logic [BIN_W-1:0]        bin;
    logic signed [POS_W-1:0] xm;
    logic signed [POS_W-1:0] ym;
    logic [PHASE_W-1:0]      phase;
    logic                    sat;
  } pose_result_t;

  pose_result_t      predicted_poses[$];
  logic [CELL_W-1:0] cell_size_q;
  logic [BINS_W-1:0] heading_bins_q;

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if (a % b != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic logic signed [POS_W-1:0] clamp_pos(input longint v, output logic hit);
    hit = 1'b0;
    if (v > POS_MAX) begin
      hit = 1'b1;
      return POS_MAX[POS_W-1:0];
    end
    if (v < POS_MIN) begin
      hit = 1'b1;
      return POS_MIN[POS_W-1:0];
    end
    return v[POS_W-1:0];
  endfunction

  function automatic pose_result_t convert_pose(cmd_t cmd,
                                                logic signed [POS_W-1:0] px,
                                                logic signed [POS_W-1:0] py,
                                                logic [PHASE_W-1:0] ph,
                                                logic signed [POS_W-1:0] gx,
                                                logic signed [POS_W-1:0] gy,
                                                logic [BIN_W-1:0] hi);
    pose_result_t r;
    longint cs, n, pv, num, idx;
    logic hx, hy;
    cs = (cell_size_q == '0) ? 64'sd1 : longint'(cell_size_q);
    n = heading_bins_q;
    if (n < 2) n = 2;
    if (n > MAX_HEADING_BINS) n = MAX_HEADING_BINS;
    r = '{default: '0};
    if (cmd == CMD_TO_GRID) begin
      pv = ph;
      // shift by half a bin, wrap to one turn, then scale to the bin count
      num = (2 * n * pv + 65536) % (131072 * n);
      r.gx = POS_W'(floor_quot(px, cs));
      r.gy = POS_W'(floor_quot(py, cs));
      r.bin = BIN_W'(num / 131072);
    end else begin
      idx = hi;
      r.xm = clamp_pos(longint'(gx) * cs + cs / 2, hx);
      r.ym = clamp_pos(longint'(gy) * cs + cs / 2, hy);
      r.sat = hx | hy;
      r.phase = PHASE_W'((idx * 65536) / n);
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  initial begin
    mismatches = 0;
    awaiting = 0;
    checked = 0;
  end

  always @(posedge clk) begin
    pose_result_t want;
    pose_result_t next_pose;
    if (rst) begin
      cell_size_q = CELL_SIZE_RESET;
      heading_bins_q = HEADING_BINS_RESET;
      predicted_poses.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (predicted_poses.size() == 0) begin
          mismatches++;
          $error("result transfer with no pose outstanding");
        end else begin
          want = predicted_poses.pop_front();
          checked++;
          check_field("out_grid_x", want.gx, out_grid_x);
          check_field("out_grid_y", want.gy, out_grid_y);
          check_field("out_heading_index", want.bin, out_heading_index);
          check_field("out_x_mm", want.xm, out_x_mm);
          check_field("out_y_mm", want.ym, out_y_mm);
          check_field("out_heading_phase", want.phase, out_heading_phase);
          check_field("saturated", want.sat, saturated);
        end
      end
      if (item_valid && !item_stall) begin
        next_pose = convert_pose(cmd_t'(command), pos_x_mm, pos_y_mm,
                                 heading_phase, grid_x, grid_y, heading_index);
        predicted_poses = {predicted_poses, next_pose};
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          REG_CELL_SIZE:    cell_size_q = cfg_data[CELL_W-1:0];
          REG_HEADING_BINS: heading_bins_q = cfg_data[BINS_W-1:0];
          default: ;
        endcase
      end
    end
    awaiting = predicted_poses.size();
  end

endmodule

>>> tb/pose_grid_quantizer_test.sv
// top of the pose grid quantizer testbench: clock, reset, register writes, pose stimulus,
// receiver stalls and the verdict; prediction and comparison sit in the checker
// depends on pgq_pkg, pose_grid_quantizer and pose_grid_quantizer_checker
module pose_grid_quantizer_test;
  import pgq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_PER_SETTING = 200;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;

  logic                    clk;
  logic                    rst;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [0:0]              cfg_index;
  logic [CFG_W-1:0]        cfg_data;
  logic                    item_valid;
  logic                    item_stall;
  logic                    command;
  logic signed [POS_W-1:0] pos_x_mm;
  logic signed [POS_W-1:0] pos_y_mm;
  logic [PHASE_W-1:0]      heading_phase;
  logic signed [POS_W-1:0] grid_x;
  logic signed [POS_W-1:0] grid_y;
  logic [BIN_W-1:0]        heading_index;
  logic                    result_valid;
  logic                    result_stall;
  logic signed [POS_W-1:0] out_grid_x;
  logic signed [POS_W-1:0] out_grid_y;
  logic [BIN_W-1:0]        out_heading_index;
  logic signed [POS_W-1:0] out_x_mm;
  logic signed [POS_W-1:0] out_y_mm;
  logic [PHASE_W-1:0]      out_heading_phase;
  logic                    saturated;

  int mismatches;
  int awaiting;
  int checked;

  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_req;
  int sent_count;
  int directed_count;
  int setting_count;
  logic [CELL_W-1:0] cur_cell;
  logic [BINS_W-1:0] cur_bins;

  pose_grid_quantizer uut (.*);

  pose_grid_quantizer_checker scoreboard (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: random stalls, or one long hold-off when asked for
  initial begin
    int hold_left;
    hold_left = 0;
    result_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 quiet, awaiting);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic longint eff_cell();
    return (cur_cell == '0) ? 64'sd1 : longint'(cur_cell);
  endfunction

  function automatic logic [31:0] pick_pos();
    longint k;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'(int'($urandom_range(0, 40000)) - 20000);
      // cell edges and their neighbours
      2: begin
        k = longint'($urandom_range(0, 4000)) - 2000;
        return 32'(k * eff_cell() + int'($urandom_range(0, 2)) - 1);
      end
      default:
        return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
                                    : 32'h80000000 + $urandom_range(0, 3);
    endcase
  endfunction

  function automatic logic [31:0] pick_cell();
    longint k;
    case ($urandom_range(0, 2))
      0: return $urandom;
      1: return 32'(int'($urandom_range(0, 2000)) - 1000);
      // around the index where the cell centre leaves 32 bits
      default: begin
        k = (64'sd1 <<< 31) / eff_cell() + int'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1)) k = -k - 1;
        return 32'(k);
      end
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_pose(cmd_t cmd, logic [31:0] px, logic [31:0] py, logic [15:0] ph,
                           logic [31:0] gx, logic [31:0] gy, logic [9:0] hi);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    command <= cmd;
    pos_x_mm <= px;
    pos_y_mm <= py;
    heading_phase <= ph;
    grid_x <= gx;
    grid_y <= gy;
    heading_index <= hi;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic make_random_pose();
    longint n, j;
    logic [15:0] ph;
    n = cur_bins;
    if (n < 2) n = 2;
    if (n > MAX_HEADING_BINS) n = MAX_HEADING_BINS;
    if ($urandom_range(0, 1)) begin
      ph = 16'($urandom);
    end else begin
      // near a multiple of half a bin: the bin edges and the bin centres
      j = $urandom_range(0, 2 * n - 1);
      ph = 16'((j * 65536) / (2 * n) + int'($urandom_range(0, 2)) - 1);
    end
    send_pose(cmd_t'($urandom_range(0, 1)), pick_pos(), pick_pos(), ph,
              pick_cell(), pick_cell(), 10'($urandom_range(0, 1023)));
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(negedge clk); while (awaiting != 0);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_grid(logic [CELL_W-1:0] cell_len, logic [BINS_W-1:0] bin_count);
    wait_drained();
    write_reg(REG_CELL_SIZE, cell_len);
    write_reg(REG_HEADING_BINS, CFG_W'(bin_count));
    cfg_valid <= 1'b0;
    cur_cell = cell_len;
    cur_bins = bin_count;
    setting_count++;
  endtask

  initial begin
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= REG_CELL_SIZE;
    cfg_data <= '0;
    item_valid <= 1'b0;
    command <= CMD_TO_GRID;
    pos_x_mm <= '0;
    pos_y_mm <= '0;
    heading_phase <= '0;
    grid_x <= '0;
    grid_y <= '0;
    heading_index <= '0;
    hold_req = 1'b0;
    tx_idle_pct = 7;
    rx_idle_pct = 78;
    sent_count = 0;
    setting_count = 1;
    cur_cell = CELL_SIZE_RESET;
    cur_bins = HEADING_BINS_RESET;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // reset grid: 2560 mm cells, 16 bins; unused fields mostly carry noise
    send_pose(CMD_TO_GRID, 0, 0, 0, $urandom, $urandom, 10'($urandom_range(0, 1023)));
    send_pose(CMD_TO_GRID, 32'h7fffffff, 32'h80000000, 16'hffff,
              $urandom, $urandom, 10'($urandom_range(0, 1023)));
    send_pose(CMD_TO_GRID, -32'sd1, 32'd1, 16'd2048, $urandom, $urandom, 10'd1023);
    send_pose(CMD_TO_GRID, -32'sd2560, 32'd2559, 16'd2047, $urandom, $urandom, 10'd0);
    // last half bin wraps back to bin zero
    send_pose(CMD_TO_GRID, 32'h80000000, 32'h7fffffff, 16'd63488,
              $urandom, $urandom, 10'($urandom_range(0, 1023)));
    send_pose(CMD_TO_GRID, -32'sd2561, 32'd2560, 16'd63487, 0, 0, 0);
    send_pose(CMD_TO_CONTINUOUS, $urandom, $urandom, 16'($urandom), 0, 0, 10'd0);
    send_pose(CMD_TO_CONTINUOUS, $urandom, $urandom, 16'($urandom),
              32'h7fffffff, 32'h80000000, 10'd15);
    // bin index past the bin count wraps around the turn
    send_pose(CMD_TO_CONTINUOUS, 0, 0, 0, 32'h80000000, 32'h7fffffff, 10'd1023);
    send_pose(CMD_TO_CONTINUOUS, $urandom, $urandom, 16'($urandom), -32'sd1, 32'd1, 10'd16);
    send_pose(CMD_TO_CONTINUOUS, 32'hffffffff, 32'hffffffff, 16'hffff,
              32'd838860, -32'sd838861, 10'd8);
    send_pose(CMD_TO_CONTINUOUS, $urandom, $urandom, 16'($urandom), 32'd838861, 32'd0, 10'd1);
    directed_count = sent_count;

    for (int setting_no = 0; setting_no < 8; setting_no++) begin
      if (setting_no == 3) begin
        tx_idle_pct = 78;
        rx_idle_pct = 7;
      end
      if (setting_no == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (setting_no)
        0: set_grid(24'd256, 11'd8);
        1: set_grid(24'd1, 11'd2);
        2: set_grid(24'hffffff, 11'd1024);
        3: set_grid(24'd0, 11'd0);
        4: set_grid(24'(1000 + $urandom_range(0, 3000)), 11'd7);
        5: set_grid(24'($urandom_range(1, 24'hffffff)), 11'd2047);
        6: set_grid(24'd3, 11'd1);
        default: set_grid(24'($urandom_range(1, 65535)), 11'($urandom_range(2, 1024)));
      endcase
      // long receiver hold-off while poses keep coming, fills the pipeline
      if (setting_no == 1) hold_req = 1'b1;
      for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
        if (setting_no == 4 && i == ITEMS_PER_SETTING / 2) wait_drained();
        make_random_pose();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("converted %0d poses (%0d directed) both ways under %0d grid settings",
             sent_count, directed_count, setting_count);
    $display("%0d results compared, with idle gaps on each side and a %0d cycle hold-off",
             checked, HOLD_CYCLES);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

>>> pose_grid_quantizer.f
hw/rtl/pgq_pkg.sv
hw/rtl/pgq_divider.sv
hw/rtl/pgq_axis_lane.sv
hw/rtl/pgq_heading_lane.sv
hw/rtl/pose_grid_quantizer.sv
tb/pose_grid_quantizer_checker.sv
tb/pose_grid_quantizer_test.sv
